// ===== rtl/assert_macros.svh =====
// assertion macros shared by the walk and top-level rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition a implies condition b in the same cycle
`define ASSERT_IMPL(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("assertion failed");

// condition a implies condition b in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("assertion failed");

`endif

// ===== rtl/cr2r_pkg.sv =====
// types, op codes and helper functions for the cigar position mapper
package cr2r_pkg;

	localparam int unsigned StartW  = 31;
	localparam int unsigned TargetW = 32;
	localparam int unsigned LenW    = 28;
	localparam int unsigned RefW    = 34;
	localparam int unsigned ReadW   = 31;

	typedef enum logic [3:0] {
		OP_M     = 4'd0,
		OP_I     = 4'd1,
		OP_D     = 4'd2,
		OP_N     = 4'd3,
		OP_S     = 4'd4,
		OP_H     = 4'd5,
		OP_P     = 4'd6,
		OP_EQ    = 4'd7,
		OP_X     = 4'd8
	} op_t;

	typedef struct packed {
		logic               first;
		logic [StartW-1:0]  start;
		logic [TargetW-1:0] target;
		logic [3:0]         op;
		logic [LenW-1:0]    len;
		logic               empty;
		logic               last;
	} item_t;

	typedef struct packed {
		logic             found;
		logic [ReadW-1:0] index;
	} result_t;

	function automatic logic eats_read(input logic [3:0] op);
		logic r;
		unique case (op) inside
			OP_M, OP_I, OP_S, OP_EQ, OP_X: r = 1'b1;
			default:                       r = 1'b0;
		endcase
		return r;
	endfunction

	function automatic logic eats_ref(input logic [3:0] op);
		logic r;
		unique case (op) inside
			OP_M, OP_D, OP_N, OP_EQ, OP_X: r = 1'b1;
			default:                       r = 1'b0;
		endcase
		return r;
	endfunction

	// read cursor add, saturating at the largest 31-bit index
	function automatic logic [ReadW-1:0] read_add(input logic [ReadW-1:0] base,
			input logic [LenW-1:0] amount);
		logic [ReadW:0] s;
		s = {1'b0, base} + {{(ReadW+1-LenW){1'b0}}, amount};
		return s[ReadW] ? {ReadW{1'b1}} : s[ReadW-1:0];
	endfunction

endpackage

// ===== rtl/cr2r_in_stage.sv =====
// input register holding one cigar element request
module cr2r_in_stage (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  cr2r_pkg::item_t item,
	input  logic           advance,
	output logic           valid_s1,
	output cr2r_pkg::item_t item_s1
);
	import cr2r_pkg::*;

	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= item;
		end
	end

endmodule

// ===== rtl/cr2r_walk.sv =====
// running walk state and per-element cursor update
module cr2r_walk (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             take,
	input  cr2r_pkg::item_t  item,
	output cr2r_pkg::result_t result
);
	import cr2r_pkg::*;
	`include "assert_macros.svh"

	logic [RefW-1:0]    ref_q, ref_b, ref_n, next_ref, adv_ref, tgt_wide, diff;
	logic [ReadW-1:0]   rd_q, rd_b, rd_n;
	logic [TargetW-1:0] tgt_q, tgt_b;
	logic               done_q, done_b, done_n;
	logic               gap_q, gap_b, gap_n;
	logic               step, gap_op, found_n;

	always_comb begin
		ref_b  = ref_q;
		rd_b   = rd_q;
		tgt_b  = tgt_q;
		done_b = done_q;
		gap_b  = gap_q;
		// first element restarts the walk
		if (item.first) begin
			tgt_b  = item.target;
			ref_b  = {{(RefW-StartW){1'b0}}, item.start} + RefW'(1);
			rd_b   = '0;
			gap_b  = 1'b0;
			done_b = ({{(RefW-TargetW){1'b0}}, item.target} == ref_b);
		end
		tgt_wide = {{(RefW-TargetW){1'b0}}, tgt_b};
		adv_ref  = eats_ref(item.op) ? {{(RefW-LenW){1'b0}}, item.len} : '0;
		next_ref = ref_b + adv_ref;
		diff     = tgt_wide - ref_b;
		gap_op   = (item.op == OP_D) || (item.op == OP_N);
		step     = !item.empty && !done_b && (ref_b <= tgt_wide);

		ref_n  = ref_b;
		rd_n   = rd_b;
		done_n = done_b;
		gap_n  = gap_b;
		if (step) begin
			if (gap_op && (ref_b < tgt_wide) && (next_ref > tgt_wide)) begin
				gap_n  = 1'b1;
				done_n = 1'b1;
			end else if (tgt_wide <= next_ref) begin
				// target lies inside this element, offset fits the length
				if (eats_read(item.op)) begin
					rd_n = read_add(rd_b, diff[LenW-1:0]);
				end
				ref_n  = tgt_wide;
				done_n = 1'b1;
			end else begin
				ref_n = next_ref;
				if (eats_read(item.op)) begin
					rd_n = read_add(rd_b, item.len);
				end
			end
		end

		found_n      = !gap_n && (ref_n == tgt_wide);
		result.found = found_n;
		result.index = found_n ? rd_n : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_q  <= '0;
			rd_q   <= '0;
			tgt_q  <= '0;
			done_q <= 1'b0;
			gap_q  <= 1'b0;
		end else if (take) begin
			ref_q  <= ref_n;
			rd_q   <= rd_n;
			tgt_q  <= tgt_b;
			done_q <= done_n;
			gap_q  <= gap_n;
		end
	end

	`ASSERT_IMPL(a_gap_ends_walk, clk, arst_n, gap_q, done_q)
	`ASSERT_NEXT(a_done_holds_ref, clk, arst_n, take && !item.first && done_q, $stable(ref_q))
	`ASSERT_IMPL(a_found_in_range, clk, arst_n, done_q && !gap_q, ref_q == RefW'(tgt_q))

endmodule

// ===== rtl/cr2r_out_stage.sv =====
// result register towards the receiver
module cr2r_out_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  cr2r_pkg::result_t result,
	output logic              slot_free,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              found,
	output logic [cr2r_pkg::ReadW-1:0] read_index
);
	import cr2r_pkg::*;

	result_t res_q;

	assign slot_free  = !out_valid || out_ready;
	assign found      = res_q.found;
	assign read_index = res_q.index;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= result;
		end
	end

endmodule

// ===== rtl/cigar_ref_to_read_position.sv =====
// top level: maps a reference position to a read index over streamed cigar elements
//
// input channel: one cigar element per request (in_valid / in_ready). the
// first element of a read carries ref_start and target_pos; empty_cigar marks
// a read with no elements, last_element closes the read.
// output channel: one request (out_valid / out_ready) per read, on its last
// element, giving found and read_index (zero when not found).
// result path: the input register takes the last element when it is accepted,
// and the walk loads the result register from it once the element advances,
// which waits for a free result register; out_valid then rises.
// throughput: one element per cycle while no closing element waits; the
// cursor update is a single add and compare pass from the walk state registers.
// when the receiver stalls, elements that give no result keep flowing; an
// element closing a read waits in the input register until the result
// register is free, and in_ready drops only then.
// reset clears the walk state to zero and empties both registers.
module cigar_ref_to_read_position (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         first_element,
	input  logic [cr2r_pkg::StartW-1:0]  ref_start,
	input  logic [cr2r_pkg::TargetW-1:0] target_pos,
	input  logic [3:0]                   op_code,
	input  logic [cr2r_pkg::LenW-1:0]    op_length,
	input  logic                         empty_cigar,
	input  logic                         last_element,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         found,
	output logic [cr2r_pkg::ReadW-1:0]   read_index
);
	import cr2r_pkg::*;
	`include "assert_macros.svh"

	item_t   item_in, item_s1;
	result_t walk_res;
	logic    valid_s1, advance, slot_free;

	assign item_in.first  = first_element;
	assign item_in.start  = ref_start;
	assign item_in.target = target_pos;
	assign item_in.op     = op_code;
	assign item_in.len    = op_length;
	assign item_in.empty  = empty_cigar;
	assign item_in.last   = last_element;

	// an element with a result needs a free result slot
	assign advance = valid_s1 && (!item_s1.last || slot_free);

	cr2r_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.item     (item_in),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	cr2r_walk u_walk (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (advance),
		.item   (item_s1),
		.result (walk_res)
	);

	cr2r_out_stage u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (advance && item_s1.last),
		.result     (walk_res),
		.slot_free  (slot_free),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.found      (found),
		.read_index (read_index)
	);

	`ASSERT_IMPL(a_ready_when_out_free, clk, arst_n, !out_valid, in_ready)
	`ASSERT_NEXT(a_last_gives_result, clk, arst_n, advance && item_s1.last, out_valid)
	`ASSERT_IMPL(a_no_index_when_missing, clk, arst_n, out_valid && !found, read_index == '0)

endmodule

// ===== sim/tb_cigar_ref_to_read_position.sv =====
// testbench for the cigar reference-to-read position mapper: predicted results, random reads
module tb_cigar_ref_to_read_position;
	import cr2r_pkg::*;

	localparam logic [3:0] OP_SPARE = 4'd12;
	localparam int unsigned QUIET_LIMIT = 4000;
	localparam int unsigned PHASE_ITEMS = 325;
	localparam int unsigned DRAIN_CYCLES = 8;

	class index_tracker;
		localparam longint unsigned READ_TOP = 64'h7FFF_FFFF;

		logic [RefW-1:0]  ref_cur;
		logic [RefW-1:0]  tgt;
		logic [ReadW-1:0] read_cur;
		bit               done;
		bit               gap;
		result_t          pending_index[$];
		int unsigned      errors;
		int unsigned      reads_closed;
		int unsigned      hits;
		int unsigned      gaps;

		function new();
			ref_cur = '0;
			tgt = '0;
			read_cur = '0;
			done = 1'b0;
			gap = 1'b0;
			errors = 0;
			reads_closed = 0;
			hits = 0;
			gaps = 0;
		endfunction

		function bit takes_bases(logic [3:0] op);
			return op inside {OP_M, OP_I, OP_S, OP_EQ, OP_X};
		endfunction

		function bit takes_ref(logic [3:0] op);
			return op inside {OP_M, OP_D, OP_N, OP_EQ, OP_X};
		endfunction

		// read index saturates at the top of its 31-bit range
		function logic [ReadW-1:0] bump(logic [ReadW-1:0] cur, logic [RefW-1:0] amount);
			longint unsigned s;
			s = longint'(cur) + longint'(amount);
			return (s > READ_TOP) ? ReadW'(READ_TOP) : ReadW'(s);
		endfunction

		function void note_element(item_t it);
			logic [RefW-1:0] start1;
			logic [RefW-1:0] nxt;
			result_t r;
			start1 = RefW'(it.start) + RefW'(1);
			if (it.first) begin
				tgt = RefW'(it.target);
				ref_cur = start1;
				read_cur = '0;
				gap = 1'b0;
				done = (tgt == start1);
			end
			if (!it.empty && !done && ref_cur <= tgt) begin
				nxt = ref_cur + (takes_ref(it.op) ? RefW'(it.len) : RefW'(0));
				if ((it.op == OP_D || it.op == OP_N) && ref_cur < tgt && nxt > tgt) begin
					gap = 1'b1;
					done = 1'b1;
				end else if (tgt <= nxt) begin
					if (takes_bases(it.op))
						read_cur = bump(read_cur, tgt - ref_cur);
					ref_cur = tgt;
					done = 1'b1;
				end else begin
					ref_cur = nxt;
					if (takes_bases(it.op))
						read_cur = bump(read_cur, RefW'(it.len));
				end
			end
			if (it.last) begin
				r.found = !gap && (ref_cur == tgt);
				r.index = r.found ? read_cur : '0;
				reads_closed++;
				if (r.found)
					hits++;
				if (gap)
					gaps++;
				pending_index = {pending_index, r};
			end
		endfunction

		task report(string what);
			errors++;
			if (errors <= 40)
				$display("mismatch: %s", what);
		endtask

		task check_index(logic got_found, logic [ReadW-1:0] got_index);
			result_t want;
			if (pending_index.size() == 0) begin
				report($sformatf("result found=%0b index=%0d with nothing pending",
					got_found, got_index));
			end else begin
				want = pending_index.pop_front();
				if (got_found !== want.found)
					report($sformatf("found %0b, predicted %0b", got_found, want.found));
				if (got_index !== want.index)
					report($sformatf("read_index %0d, predicted %0d", got_index, want.index));
			end
		endtask
	endclass

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                out_ready = 1'b0;
	item_t               elem = '0;
	logic                in_ready;
	logic                out_valid;
	logic                found;
	logic [ReadW-1:0]    read_index;
	index_tracker        board;
	int unsigned         send_idle_pct = 0;
	int unsigned         recv_stall_pct = 0;
	int unsigned         items_sent = 0;
	int unsigned         quiet = 0;

	always #10 clk = ~clk;

	cigar_ref_to_read_position u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.first_element (elem.first),
		.ref_start     (elem.start),
		.target_pos    (elem.target),
		.op_code       (elem.op),
		.op_length     (elem.len),
		.empty_cigar   (elem.empty),
		.last_element  (elem.last),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.found         (found),
		.read_index    (read_index)
	);

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				board.note_element(elem);
			if (out_valid && out_ready)
				board.check_index(found, read_index);
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				quiet <= 0;
			end else if (quiet >= QUIET_LIMIT) begin
				$display("watchdog: no request moved for %0d cycles", QUIET_LIMIT);
				$display("RESULT: ERROR");
				$finish;
			end else begin
				quiet <= quiet + 1;
			end
		end
	end

	function automatic item_t mk(bit first, logic [StartW-1:0] start,
			logic [TargetW-1:0] target, logic [3:0] op, logic [LenW-1:0] len,
			bit empty, bit last);
		item_t e;
		e.first = first;
		e.start = start;
		e.target = target;
		e.op = op;
		e.len = len;
		e.empty = empty;
		e.last = last;
		return e;
	endfunction

	task automatic send_element(item_t e);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		elem <= e;
		do @(posedge clk); while (!in_ready);
		items_sent++;
	endtask

	function automatic item_t random_element();
		item_t e;
		int unsigned p;
		e.first = 1'b0;
		e.last = 1'b0;
		e.empty = 1'b0;
		// start and target are don't-care here, so let them toggle freely
		e.start = StartW'($urandom());
		e.target = $urandom();
		e.op = ($urandom_range(99) < 6) ? 4'($urandom_range(15, 9)) : 4'($urandom_range(8, 0));
		p = $urandom_range(99);
		if (p < 80)
			e.len = LenW'($urandom_range(30, 0));
		else if (p < 95)
			e.len = LenW'($urandom_range(3000, 0));
		else
			e.len = LenW'($urandom());
		return e;
	endfunction

	task automatic send_random_read();
		item_t q[$];
		item_t e;
		int unsigned n;
		int unsigned p;
		logic [StartW-1:0] base;
		logic [TargetW-1:0] tgt;
		p = $urandom_range(99);
		if (p < 70)
			base = StartW'($urandom_range(1000000, 0));
		else if (p < 85)
			base = {StartW{1'b1}} - StartW'($urandom_range(5000, 0));
		else
			base = StartW'($urandom());
		n = $urandom_range(8, 1);
		p = $urandom_range(99);
		if (p < 55)
			tgt = TargetW'(base) + 1 + $urandom_range(n * 20, 0);
		else if (p < 65)
			tgt = TargetW'(base) + 1;
		else if (p < 75)
			tgt = TargetW'(base) + 1 - $urandom_range(50, 1);
		else if (p < 85)
			tgt = TargetW'(base) + 1 + $urandom_range(n * 20 + 2000, n * 20);
		else
			tgt = $urandom();
		for (int i = 0; i < n; i++)
			q = {q, random_element()};
		q[0].first = 1'b1;
		q[0].start = base;
		q[0].target = tgt;
		q[n-1].last = 1'b1;
		if ($urandom_range(99) < 5) begin
			// read with no elements at all
			q[0].empty = 1'b1;
			q[0].last = 1'b1;
			q = q[0:0];
		end else if ($urandom_range(99) < 12) begin
			// broken reads: lost head, restart mid-read, lost tail, stray empty, pure noise
			case ($urandom_range(4))
				0: q[0].first = 1'b0;
				1: begin
					e = q[$urandom_range(n - 1)];
					e.first = 1'b1;
					e.start = StartW'($urandom());
					e.target = $urandom();
					q = {q, e};
				end
				2: q[n-1].last = 1'b0;
				3: q[$urandom_range(n - 1)].empty = 1'b1;
				default: begin
					e = random_element();
					e.first = 1'($urandom_range(1));
					e.empty = 1'($urandom_range(1));
					e.last = 1'($urandom_range(1));
					q = {q, e};
				end
			endcase
		end
		foreach (q[i])
			send_element(q[i]);
	endtask

	initial begin
		item_t dir[$];
		int unsigned goal;
		board = new();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// element before any read has started walks the reset state
		dir = {dir, mk(0, 0, 0, OP_M, 5, 0, 1)};
		// target at start plus one, top of the start range
		dir = {dir, mk(1, {StartW{1'b1}}, 32'h8000_0000, OP_D, 10, 0, 1)};
		dir = {dir, mk(1, 0, 50, OP_M, 3, 1, 1)};
		dir = {dir, mk(1, 100, 50, OP_M, 10, 0, 1)};
		// target on the end of an M, trailing element ignored
		dir = {dir, mk(1, 10, 16, OP_M, 5, 0, 0)};
		dir = {dir, mk(0, 0, 0, OP_I, 3, 0, 1)};
		// target inside a skipped region
		dir = {dir, mk(1, 0, 8, OP_M, 3, 0, 0)};
		dir = {dir, mk(0, 0, 0, OP_N, 10, 0, 1)};
		// every op but S and N in one walk, plus a spare op code
		dir = {dir, mk(1, 0, 30, OP_H, 4, 0, 0)};
		dir = {dir, mk(0, 0, 0, OP_P, 2, 0, 0)};
		dir = {dir, mk(0, 0, 0, OP_EQ, 3, 0, 0)};
		dir = {dir, mk(0, 0, 0, OP_X, 2, 0, 0)};
		dir = {dir, mk(0, 0, 0, OP_D, 2, 0, 0)};
		dir = {dir, mk(0, 0, 0, OP_I, 4, 0, 0)};
		dir = {dir, mk(0, 0, 0, OP_SPARE, 7, 0, 0)};
		dir = {dir, mk(0, 0, 0, OP_M, 40, 0, 1)};
		// read index saturation with maximum lengths
		dir = {dir, mk(1, 0, 4, OP_S, {LenW{1'b1}}, 0, 0)};
		for (int i = 0; i < 8; i++)
			dir = {dir, mk(0, 0, 0, OP_I, {LenW{1'b1}}, 0, 0)};
		dir = {dir, mk(0, 0, 0, OP_M, 5, 0, 1)};
		foreach (dir[i])
			send_element(dir[i]);

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 45; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 45; end
				default: begin send_idle_pct = 37; recv_stall_pct = 37; end
			endcase
			goal = items_sent + PHASE_ITEMS;
			while (items_sent < goal)
				send_random_read();
		end
		in_valid <= 1'b0;
		@(posedge clk);
		while (board.pending_index.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("walked %0d cigar elements, closing %0d reads", items_sent, board.reads_closed);
		$display("%0d reads mapped to a base, %0d ended inside a deletion or skip",
			board.hits, board.gaps);
		if (board.errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
